FILE: rtl/lbc_pkg.sv
package lbc_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int BLOCK_BITS  = 24;
  localparam int SLOT_W      = $clog2(NUM_BUFFERS);

  // fixed port field widths
  localparam int OP_W    = 3;
  localparam int BLKNO_W = 24;
  localparam int IDX_W   = 4;
  localparam int KIND_W  = 2;

  localparam logic [OP_W-1:0] OP_GET     = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DELAYED = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT = 2'd0,
    KIND_WB    = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CLS_GET,
    CLS_READ,
    CLS_WRITE,
    CLS_DELAYED,
    CLS_FLUSH,
    CLS_NOP
  } op_class_e;

  typedef struct packed {
    op_class_e             cls;
    logic [BLOCK_BITS-1:0] blk;
    logic [IDX_W-1:0]      idx;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_WB,
    ST_FETCH,
    ST_GRANT,
    ST_FLUSH,
    ST_DONE
  } eng_state_e;

endpackage

FILE: rtl/lbc_if.sv
interface lbc_in_if;
  import lbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [BLKNO_W-1:0] block_number;
  logic [IDX_W-1:0]   slot_index;

  modport source (output valid, operation, block_number, slot_index, input ready);
  modport sink   (input valid, operation, block_number, slot_index, output ready);
endinterface

interface lbc_out_if;
  import lbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [IDX_W-1:0]   slot_number;
  logic [BLKNO_W-1:0] disk_block;
  logic               hit;
  logic               last;

  modport source (output valid, kind, slot_number, disk_block, hit, last, input ready);
  modport sink   (input valid, kind, slot_number, disk_block, hit, last, output ready);
endinterface

FILE: rtl/lbc_front.sv
module lbc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbc_in_if.sink        in_i,
  output logic          q_valid_o,
  output lbc_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import lbc_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item_in;
  logic [31:0] blk_ext;
  logic        push, pop;

  // classify the incoming beat
  always_comb begin
    blk_ext     = 32'(in_i.block_number);
    item_in.blk = blk_ext[BLOCK_BITS-1:0];
    item_in.idx = in_i.slot_index;
    unique case (in_i.operation)
      OP_GET:     item_in.cls = CLS_GET;
      OP_READ:    item_in.cls = CLS_READ;
      OP_WRITE:   item_in.cls = CLS_WRITE;
      OP_DELAYED: item_in.cls = CLS_DELAYED;
      OP_FLUSH:   item_in.cls = CLS_FLUSH;
      default:    item_in.cls = CLS_NOP;
    endcase
  end

  // two-entry queue
  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: rtl/lbc_engine.sv
module lbc_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lbc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  lbc_out_if.source      out_o
);
  import lbc_pkg::*;

  eng_state_e state_q, state_d;

  logic [SLOT_W-1:0]     order_q [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] tag_q   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] valid_q, dirty_q, ready_q;
  logic [NUM_BUFFERS-1:0] match_q;

  item_t                 cur_q;
  logic [SLOT_W-1:0]     s_q;
  logic [BLOCK_BITS-1:0] wb_tag_q;
  logic                  fetch_pend_q, hit_q;
  logic [SLOT_W-1:0]     fl_q;

  // resolve signals
  logic [NUM_BUFFERS-1:0] match_pos;
  logic                   found;
  logic [SLOT_W-1:0]      pos;
  logic [SLOT_W-1:0]      s_sel;
  logic                   miss;
  logic [31:0]            idx_ext;
  logic [SLOT_W-1:0]      idx_sel;
  logic                   slot_ok;
  logic                   is_lookup, is_slot;

  // emit signals
  logic                  emit_v;
  kind_e                 emit_kind;
  logic [SLOT_W-1:0]     emit_slot;
  logic                  emit_raw_idx;
  logic [BLOCK_BITS-1:0] emit_blk;
  logic                  emit_hit, emit_last;
  logic                  out_free;
  logic [31:0]           slot_ext, blk_ext;

  assign is_lookup = (cur_q.cls == CLS_GET) || (cur_q.cls == CLS_READ);
  assign is_slot   = (cur_q.cls == CLS_WRITE) || (cur_q.cls == CLS_DELAYED);
  assign out_free  = !out_o.valid || out_o.ready;
  assign slot_ext  = 32'(emit_slot);
  assign blk_ext   = 32'(emit_blk);

  // first match in recency order
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match_pos[i] = match_q[order_q[i]];
      if (match_pos[i] && !found) begin
        found = 1'b1;
        pos   = SLOT_W'(i);
      end
    end
    miss    = !found;
    s_sel   = order_q[pos];
    idx_ext = 32'(cur_q.idx);
    idx_sel = idx_ext[SLOT_W-1:0];
    slot_ok = (idx_ext < 32'(NUM_BUFFERS)) && valid_q[idx_sel];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_item_i.cls)
            CLS_GET, CLS_READ:      state_d = ST_MATCH;
            CLS_WRITE, CLS_DELAYED: state_d = ST_RESOLVE;
            CLS_FLUSH:              state_d = ST_FLUSH;
            default:                state_d = ST_DONE;
          endcase
        end
      end
      ST_MATCH: state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        if (is_lookup) begin
          if (miss && dirty_q[s_sel]) state_d = ST_WB;
          else if (cur_q.cls == CLS_READ && (miss || !ready_q[s_sel])) state_d = ST_FETCH;
          else state_d = ST_GRANT;
        end else begin
          state_d = (cur_q.cls == CLS_WRITE && slot_ok) ? ST_WB : ST_DONE;
        end
      end
      ST_WB: begin
        if (out_free) begin
          if (!is_lookup) state_d = ST_DONE;
          else if (fetch_pend_q) state_d = ST_FETCH;
          else state_d = ST_GRANT;
        end
      end
      ST_FETCH: if (out_free) state_d = ST_GRANT;
      ST_GRANT: if (out_free) state_d = ST_IDLE;
      ST_FLUSH: begin
        if ((out_free || !dirty_q[fl_q]) && fl_q == SLOT_W'(NUM_BUFFERS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // result beat selection
  always_comb begin
    emit_v       = 1'b0;
    emit_kind    = KIND_DONE;
    emit_slot    = s_q;
    emit_raw_idx = 1'b0;
    emit_blk     = cur_q.blk;
    emit_hit     = 1'b0;
    emit_last    = 1'b0;
    q_pop_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: q_pop_o = 1'b1;
      ST_WB: begin
        emit_v    = 1'b1;
        emit_kind = KIND_WB;
        emit_blk  = wb_tag_q;
      end
      ST_FETCH: begin
        emit_v    = 1'b1;
        emit_kind = KIND_FETCH;
      end
      ST_GRANT: begin
        emit_v    = 1'b1;
        emit_kind = KIND_GRANT;
        emit_hit  = hit_q;
        emit_last = 1'b1;
      end
      ST_FLUSH: begin
        emit_v    = dirty_q[fl_q];
        emit_kind = KIND_WB;
        emit_slot = fl_q;
        emit_blk  = tag_q[fl_q];
      end
      ST_DONE: begin
        emit_v       = 1'b1;
        emit_kind    = KIND_DONE;
        emit_slot    = '0;
        emit_raw_idx = is_slot;
        emit_blk     = '0;
        emit_last    = 1'b1;
      end
      default: ;
    endcase
  end

  // control and state bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      ready_q     <= '0;
      fl_q        <= '0;
      out_o.valid <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        order_q[i] <= SLOT_W'(i);
      end
    end else begin
      state_q <= state_d;
      if (out_free) out_o.valid <= emit_v;

      unique case (state_q)
        ST_IDLE: fl_q <= '0;
        ST_RESOLVE: begin
          if (is_lookup) begin
            if (miss) begin
              valid_q[s_sel] <= 1'b1;
              dirty_q[s_sel] <= 1'b0;
              ready_q[s_sel] <= (cur_q.cls == CLS_READ);
            end else if (cur_q.cls == CLS_READ) begin
              ready_q[s_sel] <= 1'b1;
            end
            // move to tail
            for (int i = 0; i < NUM_BUFFERS - 1; i++) begin
              if (SLOT_W'(i) >= pos) order_q[i] <= order_q[i + 1];
            end
            order_q[NUM_BUFFERS - 1] <= s_sel;
          end else if (slot_ok) begin
            dirty_q[idx_sel] <= (cur_q.cls == CLS_DELAYED);
            ready_q[idx_sel] <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (out_free || !dirty_q[fl_q]) begin
            if (dirty_q[fl_q]) begin
              dirty_q[fl_q] <= 1'b0;
              ready_q[fl_q] <= 1'b1;
            end
            fl_q <= fl_q + SLOT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) cur_q <= q_item_i;
    if (state_q == ST_MATCH) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        match_q[i] <= valid_q[i] && (tag_q[i] == cur_q.blk);
      end
    end
    if (state_q == ST_RESOLVE) begin
      if (is_lookup) begin
        s_q          <= s_sel;
        wb_tag_q     <= tag_q[s_sel];
        fetch_pend_q <= (cur_q.cls == CLS_READ) && (miss || !ready_q[s_sel]);
        hit_q        <= !miss && ready_q[s_sel];
        if (miss) tag_q[s_sel] <= cur_q.blk;
      end else begin
        s_q          <= idx_sel;
        wb_tag_q     <= tag_q[idx_sel];
        fetch_pend_q <= 1'b0;
        hit_q        <= 1'b0;
      end
    end
    if (out_free && emit_v) begin
      out_o.kind        <= emit_kind;
      out_o.slot_number <= emit_raw_idx ? cur_q.idx : slot_ext[IDX_W-1:0];
      out_o.disk_block  <= blk_ext[BLKNO_W-1:0];
      out_o.hit         <= emit_hit;
      out_o.last        <= emit_last;
    end
  end

endmodule

FILE: rtl/lru_block_buffer_cache.sv
// channel  dir  beat fields
// in_i     in   operation, block_number, slot_index
// out_o    out  kind, slot_number, disk_block, hit, last
//
// get/read: queue pop, parallel tag match, recency resolve and grant, with
//   a write-back and/or fetch beat ahead of the grant where needed
// write/delayed write: queue pop, resolve, write-back for a valid write slot,
//   done; flush: one slot a cycle unless a dirty slot waits on out_o.ready
// reset restores recency order to slot order and clears the valid, dirty and ready bits at once
// a two-entry queue takes input beats while the engine waits on out_o.ready
module lru_block_buffer_cache (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbc_in_if.sink    in_i,
  lbc_out_if.source out_o
);
  import lbc_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  lbc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  lbc_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

FILE: tb/sv/lru_block_buffer_cache_test.sv
`timescale 1ns / 100ps

module lru_block_buffer_cache_test;
  import lbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // one expected output beat
  typedef struct {
    kind_e                kind;
    logic [IDX_W-1:0]     slot;
    logic [BLKNO_W-1:0]   blk;
    logic                 hit;
    logic                 last;
  } cache_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();

  lru_block_buffer_cache DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cache state mirror
  logic [SLOT_W-1:0]     lru_q [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] tag_q [NUM_BUFFERS];
  logic                  vld_q [NUM_BUFFERS];
  logic                  dirty_q [NUM_BUFFERS];
  logic                  rdy_q [NUM_BUFFERS];

  cache_beat_t pending_beats[$];
  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  logic [BLOCK_BITS-1:0] recent_blks[$];

  function automatic void mirror_reset();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      lru_q[i] = SLOT_W'(i);
      tag_q[i] = '0;
      vld_q[i] = 1'b0;
      dirty_q[i] = 1'b0;
      rdy_q[i] = 1'b0;
    end
  endfunction

  function automatic void push_beat(kind_e k, int s, logic [BLKNO_W-1:0] b, logic h,
                                    logic l);
    cache_beat_t e;
    e.kind = k;
    e.slot = IDX_W'(s);
    e.blk = b;
    e.hit = h;
    e.last = l;
    pending_beats.push_back(e);
  endfunction

  function automatic void queue_writeback(int s);
    push_beat(KIND_WB, s, BLKNO_W'(tag_q[s]), 1'b0, 1'b0);
    dirty_q[s] = 1'b0;
    rdy_q[s] = 1'b1;
  endfunction

  // predict the beats of one accepted command and update the mirror
  function automatic void predict_cache_op(logic [OP_W-1:0] op, logic [BLKNO_W-1:0] bn,
                                           logic [IDX_W-1:0] idx);
    logic [BLOCK_BITS-1:0] blk;
    int pos;
    int s;
    logic [SLOT_W-1:0] moved;
    blk = bn[BLOCK_BITS-1:0];
    pos = -1;
    if (op == OP_GET || op == OP_READ) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (pos < 0 && vld_q[lru_q[i]] && tag_q[lru_q[i]] == blk) pos = i;
      end
      if (pos < 0) begin
        pos = 0;
        s = lru_q[0];
        if (dirty_q[s]) queue_writeback(s);
        tag_q[s] = blk;
        vld_q[s] = 1'b1;
        dirty_q[s] = 1'b0;
        rdy_q[s] = 1'b0;
      end else begin
        s = lru_q[pos];
      end
      moved = lru_q[pos];
      for (int i = pos; i < NUM_BUFFERS - 1; i++) lru_q[i] = lru_q[i + 1];
      lru_q[NUM_BUFFERS - 1] = moved;
      if (op == OP_GET) begin
        push_beat(KIND_GRANT, s, BLKNO_W'(blk), rdy_q[s], 1'b1);
      end else if (rdy_q[s]) begin
        push_beat(KIND_GRANT, s, BLKNO_W'(blk), 1'b1, 1'b1);
      end else begin
        push_beat(KIND_FETCH, s, BLKNO_W'(blk), 1'b0, 1'b0);
        rdy_q[s] = 1'b1;
        push_beat(KIND_GRANT, s, BLKNO_W'(blk), 1'b0, 1'b1);
      end
    end else if (op == OP_WRITE || op == OP_DELAYED) begin
      if (int'(idx) < NUM_BUFFERS && vld_q[idx]) begin
        if (op == OP_WRITE) begin
          queue_writeback(idx);
        end else begin
          dirty_q[idx] = 1'b1;
          rdy_q[idx] = 1'b1;
        end
      end
      push_beat(KIND_DONE, idx, '0, 1'b0, 1'b1);
    end else begin
      if (op == OP_FLUSH) begin
        for (int i = 0; i < NUM_BUFFERS; i++) if (dirty_q[i]) queue_writeback(i);
      end
      push_beat(KIND_DONE, 0, '0, 1'b0, 1'b1);
    end
  endfunction

  // send one command beat, idling at random beforehand
  task automatic send_cmd(logic [OP_W-1:0] op, logic [BLKNO_W-1:0] bn,
                          logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.block_number <= bn;
    in_ch.slot_index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_cache_op(op, bn, idx);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // block numbers: mostly reuse of recent ones so hits and evictions mix
  function automatic logic [BLKNO_W-1:0] pick_block();
    logic [BLKNO_W-1:0] b;
    if (recent_blks.size() > 0 && $urandom_range(99) < 60) begin
      b = recent_blks[$urandom_range(recent_blks.size() - 1)];
    end else begin
      b = BLKNO_W'($urandom);
      recent_blks.push_back(b);
      if (recent_blks.size() > 24) void'(recent_blks.pop_front());
    end
    return b;
  endfunction

  task automatic send_random(int n);
    int r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) op = OP_GET;
      else if (r < 65) op = OP_READ;
      else if (r < 78) op = OP_WRITE;
      else if (r < 92) op = OP_DELAYED;
      else if (r < 97) op = OP_FLUSH;
      else op = OP_W'($urandom_range(7, 5));
      send_cmd(op, pick_block(), IDX_W'($urandom));
    end
  endtask

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each output beat against the oldest expectation
  always @(posedge clk_i) begin
    cache_beat_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d slot=%0d blk=%h hit=%b last=%b", $time,
                 out_ch.kind, out_ch.slot_number, out_ch.disk_block, out_ch.hit,
                 out_ch.last);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (out_ch.kind !== e.kind || out_ch.slot_number !== e.slot ||
            out_ch.disk_block !== e.blk || out_ch.hit !== e.hit ||
            out_ch.last !== e.last) begin
          $display("%0t: mismatch exp kind=%0d slot=%0d blk=%h hit=%b last=%b", $time,
                   e.kind, e.slot, e.blk, e.hit, e.last);
          $display("%0t:          got kind=%0d slot=%0d blk=%h hit=%b last=%b", $time,
                   out_ch.kind, out_ch.slot_number, out_ch.disk_block, out_ch.hit,
                   out_ch.last);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_block_buffer_cache_test: errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(OP_FLUSH, '0, '0);
    send_cmd(OP_WRITE, '0, 4'd3);
    send_cmd(OP_DELAYED, '0, 4'd15);
    send_cmd(OP_GET, '0, '0);
    send_cmd(OP_GET, '0, '0);
    send_cmd(OP_READ, 24'hFFFFFF, 4'hF);
    send_cmd(OP_READ, 24'hFFFFFF, '0);
    send_cmd(OP_READ, 24'h5A5A5A, '0);
    send_cmd(OP_GET, 24'h5A5A5A, '0);
    send_cmd(OP_DELAYED, 24'hFFFFFF, 4'd0);
    send_cmd(OP_DELAYED, '0, 4'd1);
    send_cmd(OP_WRITE, '0, 4'd1);
    send_cmd(OP_FLUSH, 24'hFFFFFF, 4'hF);
    send_cmd(3'd5, 24'h123456, 4'd2);
    send_cmd(3'd6, '0, '0);
    send_cmd(3'd7, 24'hFFFFFF, 4'hF);
    wait_drained();
  endtask

  // fill the cache with dirty slots so misses evict with write-backs
  task automatic test_eviction();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      send_cmd(OP_READ, BLKNO_W'(24'h100 + i), '0);
      send_cmd(OP_DELAYED, '0, IDX_W'(i));
    end
    for (int i = 0; i < 6; i++) send_cmd(OP_GET, BLKNO_W'(24'h200 + i), '0);
    send_cmd(OP_FLUSH, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    send_random(n);
    wait_drained();
  endtask

  // receiver holds off while commands keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_off_cycles = 300;
    send_random(20);
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.block_number = '0;
    in_ch.slot_index = '0;
    out_ch.ready = 1'b0;
    mirror_reset();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_eviction();
    test_random_phase(0, 0, 80);
    test_random_phase(86, 0, 60);
    test_random_phase(0, 86, 60);
    test_random_phase(24, 24, 80);
    test_backpressure();
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("lru_block_buffer_cache_test: clean");
    end else begin
      $display("lru_block_buffer_cache_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lbc_pkg.sv
rtl/lbc_if.sv
rtl/lbc_front.sv
rtl/lbc_engine.sv
rtl/lru_block_buffer_cache.sv
tb/sv/lru_block_buffer_cache_test.sv
